// ===== hdl/bltq_pkg.sv =====
// ----------------------------------------------------------------------------
// Binary lifting tree query package
// Field widths and the operation codes shared by the tree query block.
// ----------------------------------------------------------------------------
`default_nettype none

package bltq_pkg;

   localparam int NODE_W     = 10;  // node index field
   localparam int STEP_W     = 10;  // k_steps field
   localparam int EDGE_W     = 16;  // edge weight field and result min/max
   localparam int REQ_DATA_W = 48;
   localparam int RSP_DATA_W = 48;
   localparam int REQ_USER_W = 3;
   localparam int RSP_USER_W = 2;

   typedef enum logic [2:0] {
      FN_ROOT   = 3'd0,
      FN_ATTACH = 3'd1,
      FN_LCA    = 3'd2,
      FN_KTH    = 3'd3,
      FN_KMM    = 3'd4,
      FN_PATH   = 3'd5
   } func_type;

endpackage

`default_nettype wire

// ===== hdl/binary_lifting_tree_query_top.sv =====
// ----------------------------------------------------------------------------
// Binary lifting tree query engine
// Builds a weighted rooted tree item by item and answers ancestor, common
// ancestor and edge minimum/maximum queries from jump tables held in RAM.
// ----------------------------------------------------------------------------
//
//  Channel  Direction  Handshake              Contents
//  req_     in         req_tvalid/req_tready  tuser: func; tdata: node_a,
//                                             node_b, edge_weight, k_steps
//  rsp_     out        rsp_tvalid/rsp_tready  tuser: valid_res, span_empty;
//                                             tdata: result_node, min, max
//
// One item is worked on at a time. The pace is set by the single read port
// of the table RAM, one dependent read a level.
// Reset is synchronous and clears only the sequencer and the output valid;
// the tables are not cleared. The result sits in an output register, so a
// stalled consumer only holds the engine once the next result is ready.
// ----------------------------------------------------------------------------
`default_nettype none

module binary_lifting_tree_query_top
   import bltq_pkg::*;
#(
   parameter int NODES       = 1024,
   parameter int LEVELS      = 10,
   parameter int WEIGHT_BITS = 16
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_tvalid,
   output logic                       req_tready,
   // [9:0] node_a, [19:10] node_b, [35:20] edge_weight, [45:36] k_steps
   input  wire logic [REQ_DATA_W-1:0] req_tdata,
   // [2:0] func
   input  wire logic [REQ_USER_W-1:0] req_tuser,
   output logic                       rsp_tvalid,
   input  wire logic                  rsp_tready,
   // [9:0] result_node, [25:10] min_edge, [41:26] max_edge
   output logic [RSP_DATA_W-1:0]      rsp_tdata,
   // [0] valid_res, [1] span_empty
   output logic [RSP_USER_W-1:0]      rsp_tuser
);

   // Depth values and node indexes into the depth RAM share one width.
   localparam int DW = (NODES > 1) ? $clog2(NODES) : 1;
   localparam int AW = $clog2(NODES * LEVELS);
   localparam int CW = $clog2(LEVELS + 1);
   localparam int W  = WEIGHT_BITS;
   localparam int EW = NODE_W + 2 * W;
   localparam int KC = (DW > STEP_W) ? DW : STEP_W;

   typedef enum logic [16:0] {
      S_IDLE    = 17'b00000000000000001,
      S_ROOT    = 17'b00000000000000010,
      S_ATT_L0  = 17'b00000000000000100,
      S_ATT_LVL = 17'b00000000000001000,
      S_K_CHK   = 17'b00000000000010000,
      S_K_END   = 17'b00000000000100000,
      S_CLIMB   = 17'b00000000001000000,
      S_L_DB    = 17'b00000000010000000,
      S_L_SW    = 17'b00000000100000000,
      S_L_EQ    = 17'b00000001000000000,
      S_L_JA    = 17'b00000010000000000,
      S_L_JB    = 17'b00000100000000000,
      S_L_FIN   = 17'b00001000000000000,
      S_P_DC    = 17'b00010000000000000,
      S_P_B     = 17'b00100000000000000,
      S_P_END   = 17'b01000000000000000,
      S_RESP    = 17'b10000000000000000
   } state_type;

   function automatic logic [AW-1:0] tab_addr(input logic [NODE_W-1:0] n,
                                              input logic [CW-1:0] l);
      tab_addr = AW'(AW'(n) * AW'(LEVELS)) + AW'(l);
   endfunction

   // Input unpacking.
   func_type            in_func;
   logic [NODE_W-1:0]   in_a, in_b;
   logic [EDGE_W-1:0]   in_w;
   logic [STEP_W-1:0]   in_k;

   assign in_func = func_type'(req_tuser);
   assign in_a    = req_tdata[9:0];
   assign in_b    = req_tdata[19:10];
   assign in_w    = req_tdata[35:20];
   assign in_k    = req_tdata[45:36];

   // Table RAM: {max, min, jump} per (node, level); depth RAM per node.
   logic [EW-1:0]  tab_mem_ff [NODES*LEVELS];
   logic [DW-1:0]  dep_mem_ff [NODES];
   logic [EW-1:0]  tab_rd_ff;
   logic [DW-1:0]  dep_rd_ff;
   logic [AW-1:0]  tab_raddr, tab_waddr;
   logic [EW-1:0]  tab_wdata;
   logic           tab_we;
   logic [DW-1:0]  dep_raddr, dep_waddr, dep_wdata;
   logic           dep_we;

   logic [NODE_W-1:0] rd_jump;
   logic [W-1:0]      rd_mn, rd_mx;

   assign rd_jump = tab_rd_ff[NODE_W-1:0];
   assign rd_mn   = tab_rd_ff[NODE_W +: W];
   assign rd_mx   = tab_rd_ff[NODE_W+W +: W];

   // Write-first behaviour: a read of the entry being written sees new data.
   always_ff @(posedge clock) begin
      if (tab_we) begin
         tab_mem_ff[tab_waddr] <= tab_wdata;
      end
      tab_rd_ff <= (tab_we && tab_waddr == tab_raddr) ? tab_wdata : tab_mem_ff[tab_raddr];
   end

   always_ff @(posedge clock) begin
      if (dep_we) begin
         dep_mem_ff[dep_waddr] <= dep_wdata;
      end
      dep_rd_ff <= (dep_we && dep_waddr == dep_raddr) ? dep_wdata : dep_mem_ff[dep_raddr];
   end

   // Sequencer registers.
   state_type         state_ff, state_in, ret_ff, ret_in;
   func_type          func_ff, func_in;
   logic [NODE_W-1:0] a_ff, a_in, b_ff, b_in, u_ff, u_in, v_ff, v_in;
   logic [NODE_W-1:0] node_ff, node_in, ja_ff, ja_in;
   logic [W-1:0]      w_ff, w_in, mn_ff, mn_in, mx_ff, mx_in;
   logic [STEP_W-1:0] k_ff, k_in;
   logic [CW-1:0]     lvl_ff, lvl_in;
   logic [LEVELS-1:0] steps_ff, steps_in, kb_ff, kb_in;
   logic              took_ff, took_in, fold_ff, fold_in;
   logic [EW-1:0]     prev_ff, prev_in;
   logic [DW-1:0]     da_ff, da_in, db_ff, db_in;
   logic [NODE_W-1:0] res_node_ff, res_node_in;
   logic              res_valid_ff, res_valid_in, res_empty_ff, res_empty_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   logic [RSP_DATA_W-1:0] rsp_data_ff, rsp_data_in;
   logic [RSP_USER_W-1:0] rsp_user_ff, rsp_user_in;

   // Working values.
   logic              a_ok, b_ok, k_ok, lca_fin;
   logic [NODE_W-1:0] cl_cur, nu, nv, lca_c;
   logic [W-1:0]      cl_mn, cl_mx, nw_mn, nw_mx;
   logic [DW:0]       dsum, dif_a, dif_b;
   logic [DW-1:0]     dsat, gap;
   logic [W-1:0]      w_ones;

   assign w_ones = {W{1'b1}};

   // One climb level: the node moves to the jump read last cycle, if any.
   assign cl_cur = took_ff ? rd_jump : node_ff;
   assign cl_mn  = (took_ff && fold_ff && rd_mn < mn_ff) ? rd_mn : mn_ff;
   assign cl_mx  = (took_ff && fold_ff && rd_mx > mx_ff) ? rd_mx : mx_ff;

   assign nw_mn = (rd_mn < prev_ff[NODE_W +: W]) ? rd_mn : prev_ff[NODE_W +: W];
   assign nw_mx = (rd_mx > prev_ff[NODE_W+W +: W]) ? rd_mx : prev_ff[NODE_W+W +: W];

   assign dsum  = (DW+1)'(dep_rd_ff) + (DW+1)'(1);
   assign dsat  = (dsum > (DW+1)'(NODES - 1)) ? DW'(NODES - 1) : dsum[DW-1:0];
   assign dif_a = {1'b0, da_ff} - {1'b0, dep_rd_ff};
   assign dif_b = {1'b0, db_ff} - {1'b0, dep_rd_ff};
   assign gap   = (da_ff < dep_rd_ff) ? (dep_rd_ff - da_ff) : (da_ff - dep_rd_ff);
   assign k_ok  = ((k_ff >> LEVELS) == '0) && (KC'(k_ff) <= KC'(dep_rd_ff));
   assign a_ok  = 32'(in_a) < 32'(NODES);
   assign b_ok  = 32'(in_b) < 32'(NODES);
   assign nu    = (ja_ff != rd_jump) ? ja_ff : u_ff;
   assign nv    = (ja_ff != rd_jump) ? rd_jump : v_ff;

   always_comb begin
      state_in     = state_ff;
      ret_in       = ret_ff;
      func_in      = func_ff;
      a_in         = a_ff;
      b_in         = b_ff;
      u_in         = u_ff;
      v_in         = v_ff;
      node_in      = node_ff;
      ja_in        = ja_ff;
      w_in         = w_ff;
      mn_in        = mn_ff;
      mx_in        = mx_ff;
      k_in         = k_ff;
      lvl_in       = lvl_ff;
      steps_in     = steps_ff;
      kb_in        = kb_ff;
      took_in      = took_ff;
      fold_in      = fold_ff;
      prev_in      = prev_ff;
      da_in        = da_ff;
      db_in        = db_ff;
      res_node_in  = res_node_ff;
      res_valid_in = res_valid_ff;
      res_empty_in = res_empty_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_data_in  = rsp_data_ff;
      rsp_user_in  = rsp_user_ff;
      tab_we       = 1'b0;
      tab_waddr    = '0;
      tab_wdata    = '0;
      tab_raddr    = '0;
      dep_we       = 1'b0;
      dep_waddr    = '0;
      dep_wdata    = '0;
      dep_raddr    = DW'((in_func == FN_ATTACH) ? in_b : in_a);
      lca_fin      = 1'b0;
      lca_c        = '0;

      case (state_ff)
         S_IDLE: begin
            if (req_tvalid) begin
               func_in      = in_func;
               a_in         = in_a;
               b_in         = in_b;
               w_in         = W'(in_w);
               k_in         = in_k;
               lvl_in       = '0;
               res_node_in  = '0;
               res_valid_in = 1'b0;
               res_empty_in = 1'b1;
               case (in_func)
                  FN_ROOT:   state_in = a_ok ? S_ROOT : S_RESP;
                  FN_ATTACH: state_in = (a_ok && b_ok) ? S_ATT_L0 : S_RESP;
                  FN_LCA,
                  FN_PATH:   state_in = (a_ok && b_ok) ? S_L_DB : S_RESP;
                  FN_KTH,
                  FN_KMM:    state_in = a_ok ? S_K_CHK : S_RESP;
                  default:   state_in = S_RESP;
               endcase
            end
         end
         S_ROOT: begin
            tab_we    = 1'b1;
            tab_waddr = tab_addr(a_ff, lvl_ff);
            tab_wdata = {{W{1'b0}}, w_ones, a_ff};
            dep_we    = (lvl_ff == '0);
            dep_waddr = DW'(a_ff);
            dep_wdata = '0;
            lvl_in    = lvl_ff + 1'b1;
            if (lvl_ff == CW'(LEVELS - 1)) begin
               res_valid_in = 1'b1;
               state_in     = S_RESP;
            end
         end
         S_ATT_L0: begin
            dep_we    = 1'b1;
            dep_waddr = DW'(a_ff);
            dep_wdata = dsat;
            tab_we    = 1'b1;
            tab_waddr = tab_addr(a_ff, '0);
            tab_wdata = {w_ff, w_ff, b_ff};
            prev_in   = {w_ff, w_ff, b_ff};
            if (LEVELS == 1) begin
               res_valid_in = 1'b1;
               state_in     = S_RESP;
            end else begin
               tab_raddr = tab_addr(b_ff, '0);
               lvl_in    = CW'(1);
               state_in  = S_ATT_LVL;
            end
         end
         S_ATT_LVL: begin
            // Level i of the child joins its level i-1 and that of its midpoint.
            tab_we    = 1'b1;
            tab_waddr = tab_addr(a_ff, lvl_ff);
            tab_wdata = {nw_mx, nw_mn, rd_jump};
            prev_in   = {nw_mx, nw_mn, rd_jump};
            if (lvl_ff == CW'(LEVELS - 1)) begin
               res_valid_in = 1'b1;
               state_in     = S_RESP;
            end else begin
               tab_raddr = tab_addr(rd_jump, lvl_ff);
               lvl_in    = lvl_ff + 1'b1;
            end
         end
         S_K_CHK: begin
            if (!k_ok) begin
               state_in = S_RESP;
            end else if (k_ff == '0) begin
               res_valid_in = 1'b1;
               res_node_in  = (func_ff == FN_KTH) ? a_ff : '0;
               state_in     = S_RESP;
            end else begin
               node_in  = a_ff;
               steps_in = LEVELS'(k_ff);
               took_in  = 1'b0;
               lvl_in   = '0;
               fold_in  = (func_ff == FN_KMM);
               mn_in    = w_ones;
               mx_in    = '0;
               ret_in   = S_K_END;
               state_in = S_CLIMB;
            end
         end
         S_CLIMB: begin
            node_in = cl_cur;
            mn_in   = cl_mn;
            mx_in   = cl_mx;
            took_in = 1'b0;
            if (lvl_ff == CW'(LEVELS)) begin
               state_in = ret_ff;
            end else begin
               if (steps_ff[0]) begin
                  tab_raddr = tab_addr(cl_cur, lvl_ff);
                  took_in   = 1'b1;
               end
               steps_in = steps_ff >> 1;
               lvl_in   = lvl_ff + 1'b1;
            end
         end
         S_K_END: begin
            res_valid_in = 1'b1;
            if (func_ff == FN_KTH) begin
               res_node_in = node_ff;
            end else begin
               res_empty_in = 1'b0;
            end
            state_in = S_RESP;
         end
         S_L_DB: begin
            da_in     = dep_rd_ff;
            dep_raddr = DW'(b_ff);
            state_in  = S_L_SW;
         end
         S_L_SW: begin
            // Bring the deeper node up to the depth of the other one.
            db_in    = dep_rd_ff;
            node_in  = (da_ff < dep_rd_ff) ? b_ff : a_ff;
            v_in     = (da_ff < dep_rd_ff) ? a_ff : b_ff;
            steps_in = LEVELS'(gap);
            took_in  = 1'b0;
            lvl_in   = '0;
            fold_in  = 1'b0;
            ret_in   = S_L_EQ;
            state_in = S_CLIMB;
         end
         S_L_EQ: begin
            if (node_ff == v_ff) begin
               lca_fin = 1'b1;
               lca_c   = node_ff;
            end else begin
               u_in      = node_ff;
               lvl_in    = CW'(LEVELS - 1);
               tab_raddr = tab_addr(node_ff, CW'(LEVELS - 1));
               state_in  = S_L_JA;
            end
         end
         S_L_JA: begin
            ja_in     = rd_jump;
            tab_raddr = tab_addr(v_ff, lvl_ff);
            state_in  = S_L_JB;
         end
         S_L_JB: begin
            u_in = nu;
            v_in = nv;
            if (lvl_ff == '0) begin
               tab_raddr = tab_addr(nu, '0);
               state_in  = S_L_FIN;
            end else begin
               tab_raddr = tab_addr(nu, lvl_ff - 1'b1);
               lvl_in    = lvl_ff - 1'b1;
               state_in  = S_L_JA;
            end
         end
         S_L_FIN: begin
            lca_fin = 1'b1;
            lca_c   = rd_jump;
         end
         S_P_DC: begin
            if (dif_a == '0 && dif_b == '0) begin
               res_valid_in = 1'b1;
               state_in     = S_RESP;
            end else begin
               mn_in    = w_ones;
               mx_in    = '0;
               node_in  = a_ff;
               steps_in = LEVELS'($signed(dif_a));
               kb_in    = LEVELS'($signed(dif_b));
               took_in  = 1'b0;
               lvl_in   = '0;
               fold_in  = 1'b1;
               ret_in   = S_P_B;
               state_in = S_CLIMB;
            end
         end
         S_P_B: begin
            node_in  = b_ff;
            steps_in = kb_ff;
            took_in  = 1'b0;
            lvl_in   = '0;
            ret_in   = S_P_END;
            state_in = S_CLIMB;
         end
         S_P_END: begin
            res_valid_in = 1'b1;
            res_empty_in = 1'b0;
            state_in     = S_RESP;
         end
         S_RESP: begin
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = {6'b0,
                               res_empty_ff ? {EDGE_W{1'b0}} : EDGE_W'(mx_ff),
                               res_empty_ff ? {EDGE_W{1'b0}} : EDGE_W'(mn_ff),
                               res_node_ff};
               rsp_user_in  = {res_empty_ff, res_valid_ff};
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase

      // Common ancestor found: answer it, or fetch its depth for the path.
      if (lca_fin) begin
         if (func_ff == FN_LCA) begin
            res_node_in  = lca_c;
            res_valid_in = 1'b1;
            state_in     = S_RESP;
         end else begin
            dep_raddr = DW'(lca_c);
            state_in  = S_P_DC;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      ret_ff       <= ret_in;
      func_ff      <= func_in;
      a_ff         <= a_in;
      b_ff         <= b_in;
      u_ff         <= u_in;
      v_ff         <= v_in;
      node_ff      <= node_in;
      ja_ff        <= ja_in;
      w_ff         <= w_in;
      mn_ff        <= mn_in;
      mx_ff        <= mx_in;
      k_ff         <= k_in;
      lvl_ff       <= lvl_in;
      steps_ff     <= steps_in;
      kb_ff        <= kb_in;
      took_ff      <= took_in;
      fold_ff      <= fold_in;
      prev_ff      <= prev_in;
      da_ff        <= da_in;
      db_ff        <= db_in;
      res_node_ff  <= res_node_in;
      res_valid_ff <= res_valid_in;
      res_empty_ff <= res_empty_in;
      rsp_data_ff  <= rsp_data_in;
      rsp_user_ff  <= rsp_user_in;
   end

   assign req_tready = (state_ff == S_IDLE);
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_user_ff;

   // The tables are never written while the engine waits for an item.
   a_idle_no_write: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_IDLE) |-> (!tab_we && !dep_we))
      else $error("table write while idle");

   // A refused item carries no node and no span.
   a_refused_clean: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_user_ff[0]) |-> (rsp_data_ff == '0 && rsp_user_ff[1]))
      else $error("refused result carries data");

   // An empty span reports zero for both extremes.
   a_empty_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_user_ff[1]) |-> (rsp_data_ff[41:10] == '0))
      else $error("empty span with nonzero min or max");

   // The climb counter never runs past the last level.
   a_climb_bound: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_CLIMB) |-> (lvl_ff <= CW'(LEVELS)))
      else $error("climb level out of range");

   // A new result is only loaded once the previous one has been taken.
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_tready && state_ff == S_RESP) |=> (state_ff == S_RESP))
      else $error("result overwritten before transfer");

endmodule

`default_nettype wire

// ===== bench/bltq_checker.sv =====
// ----------------------------------------------------------------------------
// Binary lifting tree query checker
// Watches both channels, keeps its own copy of the jump, minimum, maximum and
// depth tables, predicts each response and compares it field by field.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module bltq_checker
   import bltq_pkg::*;
#(
   parameter int NODES  = 1024,
   parameter int LEVELS = 10
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_tvalid,
   input  wire logic                  req_tready,
   input  wire logic [REQ_DATA_W-1:0] req_tdata,
   input  wire logic [REQ_USER_W-1:0] req_tuser,
   input  wire logic                  rsp_tvalid,
   input  wire logic                  rsp_tready,
   input  wire logic [RSP_DATA_W-1:0] rsp_tdata,
   input  wire logic [RSP_USER_W-1:0] rsp_tuser,
   output int                         fail_count,
   output int                         pending
);

   typedef struct packed {
      logic [NODE_W-1:0] node;
      logic              ok;
      logic [EDGE_W-1:0] lo;
      logic [EDGE_W-1:0] hi;
      logic              empty;
   } answer_type;

   bit [NODE_W-1:0] up_node [NODES*LEVELS];
   bit [EDGE_W-1:0] lo_edge [NODES*LEVELS];
   bit [EDGE_W-1:0] hi_edge [NODES*LEVELS];
   bit [NODE_W-1:0] depth   [NODES];

   answer_type answers_due[$];

   function automatic int slot(input int node, input int lvl);
      return node * LEVELS + lvl;
   endfunction

   function automatic int ascend(input int node, input bit [NODE_W-1:0] k);
      for (int i = 0; i < LEVELS; i++)
         if (k[i]) node = up_node[slot(node, i)];
      return node;
   endfunction

   function automatic int meet(input int a, input int b);
      int t;
      int ja;
      int jb;
      if (depth[a] < depth[b]) begin
         t = a;
         a = b;
         b = t;
      end
      a = ascend(a, depth[a] - depth[b]);
      if (a == b) return a;
      for (int i = LEVELS - 1; i >= 0; i--) begin
         ja = up_node[slot(a, i)];
         jb = up_node[slot(b, i)];
         if (ja != jb) begin
            a = ja;
            b = jb;
         end
      end
      return up_node[slot(a, 0)];
   endfunction

   // Folds the edges over the k steps above a node into the running extremes.
   function automatic void fold_span(input int node, input bit [NODE_W-1:0] k,
                                     inout bit [EDGE_W-1:0] lo,
                                     inout bit [EDGE_W-1:0] hi);
      int e;
      for (int i = 0; i < LEVELS; i++) begin
         if (k[i]) begin
            e = slot(node, i);
            if (lo_edge[e] < lo) lo = lo_edge[e];
            if (hi_edge[e] > hi) hi = hi_edge[e];
            node = up_node[e];
         end
      end
   endfunction

   function automatic answer_type tree_step(input logic [2:0] fn, input int a, input int b,
                                            input bit [EDGE_W-1:0] w,
                                            input bit [NODE_W-1:0] k);
      answer_type r;
      int mid;
      int c;
      bit [NODE_W-1:0] ka;
      bit [NODE_W-1:0] kb;
      bit [EDGE_W-1:0] lo;
      bit [EDGE_W-1:0] hi;
      r = '{node: '0, ok: 1'b0, lo: '0, hi: '0, empty: 1'b1};
      case (fn)
         FN_ROOT: begin
            depth[a] = '0;
            for (int i = 0; i < LEVELS; i++) begin
               up_node[slot(a, i)] = NODE_W'(a);
               lo_edge[slot(a, i)] = '1;
               hi_edge[slot(a, i)] = '0;
            end
            r.ok = 1'b1;
         end
         FN_ATTACH: begin
            depth[a] = (depth[b] == NODE_W'(NODES - 1)) ? depth[b]
                                                        : depth[b] + NODE_W'(1);
            up_node[slot(a, 0)] = NODE_W'(b);
            lo_edge[slot(a, 0)] = w;
            hi_edge[slot(a, 0)] = w;
            for (int i = 1; i < LEVELS; i++) begin
               mid = up_node[slot(a, i - 1)];
               lo = lo_edge[slot(a, i - 1)];
               hi = hi_edge[slot(a, i - 1)];
               if (lo_edge[slot(mid, i - 1)] < lo) lo = lo_edge[slot(mid, i - 1)];
               if (hi_edge[slot(mid, i - 1)] > hi) hi = hi_edge[slot(mid, i - 1)];
               up_node[slot(a, i)] = up_node[slot(mid, i - 1)];
               lo_edge[slot(a, i)] = lo;
               hi_edge[slot(a, i)] = hi;
            end
            r.ok = 1'b1;
         end
         FN_LCA: begin
            r.node = NODE_W'(meet(a, b));
            r.ok = 1'b1;
         end
         FN_KTH: begin
            if (k <= depth[a]) begin
               r.node = NODE_W'(ascend(a, k));
               r.ok = 1'b1;
            end
         end
         FN_KMM: begin
            if (k <= depth[a]) begin
               r.ok = 1'b1;
               if (k != 0) begin
                  lo = '1;
                  hi = '0;
                  fold_span(a, k, lo, hi);
                  r.lo = lo;
                  r.hi = hi;
                  r.empty = 1'b0;
               end
            end
         end
         FN_PATH: begin
            c = meet(a, b);
            ka = depth[a] - depth[c];
            kb = depth[b] - depth[c];
            r.ok = 1'b1;
            if (ka != 0 || kb != 0) begin
               lo = '1;
               hi = '0;
               fold_span(a, ka, lo, hi);
               fold_span(b, kb, lo, hi);
               r.lo = lo;
               r.hi = hi;
               r.empty = 1'b0;
            end
         end
         default: ;
      endcase
      return r;
   endfunction

   assign pending = answers_due.size();

   always @(posedge clock) begin
      answer_type want;
      answer_type got;
      if (reset) begin
         fail_count <= 0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            got = '{node: rsp_tdata[9:0], ok: rsp_tuser[0], lo: rsp_tdata[25:10],
                    hi: rsp_tdata[41:26], empty: rsp_tuser[1]};
            if (answers_due.size() == 0) begin
               if (fail_count < 10)
                  $display("%0t: unexpected response %p", $realtime, got);
               fail_count <= fail_count + 1;
            end else begin
               want = answers_due.pop_front();
               if (got !== want) begin
                  if (fail_count < 10)
                     $display("%0t: response wrong, expected %p, got %p",
                              $realtime, want, got);
                  fail_count <= fail_count + 1;
               end
            end
         end
         if (req_tvalid && req_tready)
            answers_due.push_back(tree_step(req_tuser, req_tdata[9:0], req_tdata[19:10],
                                            req_tdata[35:20], req_tdata[45:36]));
      end
   end

endmodule

`default_nettype wire

// ===== bench/tb_binary_lifting_tree_query_top.sv =====
// ----------------------------------------------------------------------------
// Binary lifting tree query testbench
// Builds random weighted trees through the request channel and fires common
// ancestor, k-th ancestor and edge extreme queries at them, with random gaps
// on both channels; a separate checker predicts and compares every response.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module tb_binary_lifting_tree_query_top;
   import bltq_pkg::*;

   localparam int NODES      = 1024;
   localparam int STALL_SPAN = 300;    // length of the long receiver hold-off
   localparam int IDLE_LIMIT = 5000;   // cycles without any transfer

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [REQ_DATA_W-1:0] req_tdata = '0;
   logic [REQ_USER_W-1:0] req_tuser = '0;
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0] rsp_tdata;
   logic [RSP_USER_W-1:0] rsp_tuser;

   int  fail_count;
   int  pending;
   int  idle_cycles;
   int  sent_per_func [8];
   bit  calm;            // no idling on either side once set
   bit  hold_wanted;     // asks the receiver for one long hold-off
   bit  placed [NODES];  // nodes already in the tree, so no blank entry is read
   int  tree_nodes[$];

   always #2 clock = ~clock;

   binary_lifting_tree_query_top dut (
      .clock     (clock),
      .reset     (reset),
      .req_tvalid(req_tvalid),
      .req_tready(req_tready),
      .req_tdata (req_tdata),
      .req_tuser (req_tuser),
      .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready),
      .rsp_tdata (rsp_tdata),
      .rsp_tuser (rsp_tuser)
   );

   bltq_checker check_unit (
      .clock     (clock),
      .reset     (reset),
      .req_tvalid(req_tvalid),
      .req_tready(req_tready),
      .req_tdata (req_tdata),
      .req_tuser (req_tuser),
      .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready),
      .rsp_tdata (rsp_tdata),
      .rsp_tuser (rsp_tuser),
      .fail_count(fail_count),
      .pending   (pending)
   );

   // The watchdog only counts cycles in which neither channel moves a
   // transfer, so slow but live runs are never cut short.
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready))
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
         $display("binary_lifting_tree_query_top: mismatch");
         $finish;
      end
   end

   // Receiver: short random stalls, and once a long hold-off while the sender
   // keeps offering items, so that the engine backs up and drops req_tready.
   initial begin
      forever begin
         @(negedge clock);
         if (hold_wanted) begin
            hold_wanted = 1'b0;
            rsp_tready  = 1'b0;
            repeat (STALL_SPAN - 1) @(negedge clock);
         end else if (!calm && $urandom_range(0, 5) == 0) begin
            rsp_tready = 1'b0;
            repeat ($urandom_range(0, 3)) @(negedge clock);
         end else begin
            rsp_tready = 1'b1;
         end
      end
   end

   // Offers one item from a falling edge and returns at the falling edge after
   // its transfer. Valid stays high between back-to-back items.
   task automatic send_item(input logic [2:0] fn, input int a, input int b,
                            input int w, input int k);
      logic [NODE_W-1:0] na;
      logic [NODE_W-1:0] nb;
      logic [EDGE_W-1:0] nw;
      logic [STEP_W-1:0] nk;
      na = NODE_W'(a);
      nb = NODE_W'(b);
      nw = EDGE_W'(w);
      nk = STEP_W'(k);
      if (!calm && $urandom_range(0, 4) == 0) begin
         req_tvalid = 1'b0;
         repeat ($urandom_range(1, 4)) @(negedge clock);
      end
      req_tuser  = fn;
      req_tdata  = {2'b00, nk, nw, nb, na};
      req_tvalid = 1'b1;
      do @(posedge clock); while (!req_tready);
      @(negedge clock);
      sent_per_func[fn]++;
      if (fn == FN_ROOT || fn == FN_ATTACH) begin
         if (!placed[a]) tree_nodes.push_back(a);
         placed[a] = 1'b1;
      end
   endtask

   function automatic int any_placed();
      return tree_nodes[$urandom_range(0, tree_nodes.size() - 1)];
   endfunction

   function automatic int fresh_node();
      int n;
      if (tree_nodes.size() == NODES) return any_placed();
      do n = $urandom_range(0, NODES - 1); while (placed[n]);
      return n;
   endfunction

   // Mostly small step counts so the k-th queries land inside the tree, with
   // the odd full-range value to hit the refusal when k passes the depth.
   function automatic int some_k();
      if ($urandom_range(0, 5) == 0) return $urandom_range(0, 1023);
      return $urandom_range(0, 12);
   endfunction

   initial begin
      int pick;
      int last_child;
      idle_cycles = 0;
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // Directed part: field extremes, every operation, refused codes, a
      // cycle made by attaching a node below its own descendant, re-rooting.
      send_item(FN_ROOT,   0,    0,    0,     0);
      send_item(FN_ATTACH, 1023, 0,    65535, 0);
      send_item(FN_ATTACH, 5,    1023, 0,     0);
      send_item(FN_ATTACH, 6,    1023, 1234,  0);
      send_item(FN_ATTACH, 7,    5,    777,   0);
      send_item(FN_LCA,    7,    6,    0,     0);
      send_item(FN_LCA,    0,    0,    0,     0);
      send_item(FN_KTH,    7,    0,    0,     0);
      send_item(FN_KTH,    7,    0,    0,     3);
      send_item(FN_KTH,    7,    0,    0,     4);
      send_item(FN_KTH,    7,    0,    0,     1023);
      send_item(FN_KMM,    7,    0,    0,     0);
      send_item(FN_KMM,    7,    0,    0,     3);
      send_item(FN_PATH,   7,    6,    0,     0);
      send_item(FN_PATH,   7,    7,    0,     0);
      send_item(FN_PATH,   0,    7,    0,     0);
      send_item(3'd6,      7,    6,    0,     0);
      send_item(3'd7,      1023, 1023, 65535, 1023);
      send_item(FN_ATTACH, 5,    7,    4242,  0);
      send_item(FN_LCA,    7,    6,    0,     0);
      send_item(FN_PATH,   6,    5,    0,     0);
      send_item(FN_KMM,    5,    0,    0,     2);
      send_item(FN_ROOT,   1023, 0,    0,     0);
      send_item(FN_KTH,    7,    0,    0,     2);

      // Random part: some growth plus mostly queries over the trees built so far.
      last_child = 7;
      for (int n = 0; n < 425; n++) begin
         if (n == 120) hold_wanted = 1'b1;
         if (n == 360) calm = 1'b1;
         pick = $urandom_range(0, 99);
         if (pick < 25) begin
            pick = fresh_node();
            send_item(FN_ATTACH, pick, any_placed(), $urandom_range(0, 65535), 0);
            last_child = pick;
         end else if (pick < 35) begin
            // Chains under the newest node give deep spans to climb.
            pick = fresh_node();
            send_item(FN_ATTACH, pick, last_child, $urandom_range(0, 65535), 0);
            last_child = pick;
         end else if (pick < 38) begin
            send_item(FN_ATTACH, any_placed(), any_placed(), $urandom_range(0, 65535), 0);
         end else if (pick < 40) begin
            send_item(FN_ROOT, fresh_node(), 0, 0, 0);
         end else if (pick < 53) begin
            send_item(FN_LCA, any_placed(), any_placed(), 0, 0);
         end else if (pick < 68) begin
            send_item(FN_KTH, $urandom_range(0, 1) ? last_child : any_placed(),
                      0, 0, some_k());
         end else if (pick < 83) begin
            send_item(FN_KMM, $urandom_range(0, 1) ? last_child : any_placed(),
                      0, 0, some_k());
         end else if (pick < 97) begin
            send_item(FN_PATH, any_placed(), any_placed(), 0, 0);
         end else begin
            send_item(3'($urandom_range(6, 7)), any_placed(), any_placed(),
                      $urandom_range(0, 65535), $urandom_range(0, 1023));
         end
      end
      req_tvalid = 1'b0;

      wait (pending == 0);
      repeat (100) @(posedge clock);
      $display("Covered %0d tree nodes: %0d roots, %0d attaches, %0d ancestor pairs,",
               tree_nodes.size(), sent_per_func[FN_ROOT], sent_per_func[FN_ATTACH],
               sent_per_func[FN_LCA]);
      $display("%0d k-th ancestors, %0d k-step spans, %0d paths, %0d refused codes.",
               sent_per_func[FN_KTH], sent_per_func[FN_KMM], sent_per_func[FN_PATH],
               sent_per_func[6] + sent_per_func[7]);
      if (fail_count == 0)
         $display("binary_lifting_tree_query_top: match");
      else
         $display("binary_lifting_tree_query_top: mismatch");
      $finish;
   end

endmodule

`default_nettype wire

// ===== filelist.f =====
hdl/bltq_pkg.sv
hdl/binary_lifting_tree_query_top.sv
bench/bltq_checker.sv
bench/tb_binary_lifting_tree_query_top.sv
